/* src/smr_pkg.sv */
// Shared types, constants and the 2^(-k/16) table for the softmax top-k router.
`timescale 1ns / 1ps

package smr_pkg;

	localparam int LOGIT_W  = 16;   // signed Q7.8 gate logit
	localparam int EXP_W    = 17;   // exp value, Q1.16, at most 65536
	localparam int SUM_W    = 24;   // running sum of exp values
	localparam int NUM_W    = 34;   // dividend: exp << 16 plus half the sum
	localparam int OUT_IDX_W = 4;   // expert index on the result port
	localparam int WEIGHT_W = 16;   // softmax weight, Q0.16
	localparam int Y_W      = 25;   // product of a 16-bit difference and log2(e)
	localparam int DIFF_W   = 12;   // gap between neighboring table entries
	localparam int FRAC_W   = 12;   // interpolation fraction

	localparam logic [8:0] LOG2E_Q8 = 9'd369;
	localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = 16'sh8000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 16'hFFFF;

	// round(65536 * 2^(-k/16)) for k = 0..16, Q1.16
	function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] k);
		logic [EXP_W-1:0] v;
		begin
			case (k)
				5'd0:  v = 17'd65536;
				5'd1:  v = 17'd62757;
				5'd2:  v = 17'd60097;
				5'd3:  v = 17'd57549;
				5'd4:  v = 17'd55109;
				5'd5:  v = 17'd52773;
				5'd6:  v = 17'd50535;
				5'd7:  v = 17'd48393;
				5'd8:  v = 17'd46341;
				5'd9:  v = 17'd44376;
				5'd10: v = 17'd42495;
				5'd11: v = 17'd40693;
				5'd12: v = 17'd38968;
				5'd13: v = 17'd37316;
				5'd14: v = 17'd35734;
				5'd15: v = 17'd34219;
				5'd16: v = 17'd32768;
				default: v = 17'd32768;
			endcase
			return v;
		end
	endfunction

endpackage

/* src/softmax_top_k_expert_router_unit.sv */
// Top level of the softmax top-k expert router: load, exp sum, and weighted results.
`timescale 1ns / 1ps

// Flow: a set of NUM_EXPERTS logits loads at one item per cycle; the exp sum then
// runs each expert through a store read, an issue and three exp stages, and each chosen
// expert goes through exp, the bit-serial divide and the output handoff before its item
// shows. The shared exp unit and the bit-serial divider take one expert at a time;
// input is not ready between the last logit and the last result item. Reset is
// asynchronous, active low, and clears all set state but the weight register.

module softmax_top_k_expert_router_unit #(
	parameter int NUM_EXPERTS = 12,
	parameter int NUM_CHOSEN  = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side: gate_logit[15:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	// master side: expert_index[3:0], expert_weight[19:4], zero pad [23:20]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast      // last_choice
);

	localparam int IDX_W = $clog2(NUM_EXPERTS);
	localparam int KW    = (NUM_CHOSEN > 1) ? $clog2(NUM_CHOSEN) : 1;
	localparam int NRES  = (NUM_CHOSEN < NUM_EXPERTS) ? NUM_CHOSEN : NUM_EXPERTS;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SUM_RD,
		ST_SUM_EXP,
		ST_SUM_WAIT,
		ST_SEL_EXP,
		ST_SEL_WAIT,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	state_t state_q;

	// set state
	logic [IDX_W-1:0]                        cnt_q;
	logic signed [smr_pkg::LOGIT_W-1:0]      max_q;
	logic [IDX_W-1:0]                        best_idx_q   [NUM_CHOSEN];
	logic signed [smr_pkg::LOGIT_W-1:0]      best_logit_q [NUM_CHOSEN];
	logic [smr_pkg::SUM_W-1:0]               sum_q;
	logic [IDX_W-1:0]                        rd_idx_q;
	logic [KW-1:0]                           k_q;
	logic [smr_pkg::WEIGHT_W-1:0]            weight_q;
	logic                                    m_valid_q;

	// logit store
	logic signed [smr_pkg::LOGIT_W-1:0]      logit_mem [NUM_EXPERTS];
	logic signed [smr_pkg::LOGIT_W-1:0]      rd_data_q;

	logic                                    in_acc;
	logic signed [smr_pkg::LOGIT_W-1:0]      s_logit;
	logic                                    ins_found;
	logic [KW-1:0]                           ins_pos;

	logic                                    exp_start;
	logic [smr_pkg::LOGIT_W-1:0]             exp_diff;
	logic                                    exp_done;
	logic [smr_pkg::EXP_W-1:0]               exp_res;

	logic                                    div_start;
	logic [smr_pkg::NUM_W-1:0]               div_num;
	logic                                    div_done;
	logic [smr_pkg::NUM_W-1:0]               div_quo;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_logit       = signed'(s_axis_tdata);

	// find the first slot the new logit takes: an empty slot, or a strictly smaller entry
	always_comb begin
		ins_found = 1'b0;
		ins_pos   = '0;
		for (int k = 0; k < NUM_CHOSEN; k++) begin
			if (!ins_found && (k >= int'(cnt_q) || s_logit > best_logit_q[k])) begin
				ins_found = 1'b1;
				ins_pos   = KW'(k);
			end
		end
	end

	// store write on accept, registered read for the sum pass
	always_ff @(posedge clk) begin
		if (in_acc)
			logit_mem[cnt_q] <= s_logit;
		rd_data_q <= logit_mem[rd_idx_q];
	end

	// shared exp unit: stored logits during the sum, chosen logits afterward
	assign exp_start = (state_q == ST_SUM_EXP) || (state_q == ST_SEL_EXP);
	assign exp_diff  = (state_q == ST_SUM_EXP) ? smr_pkg::LOGIT_W'(max_q - rd_data_q)
	                                           : smr_pkg::LOGIT_W'(max_q - best_logit_q[k_q]);

	smr_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.diff   (exp_diff),
		.done   (exp_done),
		.result (exp_res)
	);

	// round to nearest: add half the divisor before dividing
	assign div_start = (state_q == ST_SEL_WAIT) && exp_done;
	assign div_num   = {1'b0, exp_res, 16'd0}
	                 + smr_pkg::NUM_W'(sum_q[smr_pkg::SUM_W-1:1]);

	smr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			max_q     <= smr_pkg::LOGIT_MIN;
			sum_q     <= '0;
			rd_idx_q  <= '0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
			for (int j = 0; j < NUM_CHOSEN; j++) begin
				best_idx_q[j]   <= '0;
				best_logit_q[j] <= smr_pkg::LOGIT_MIN;
			end
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (s_logit > max_q)
							max_q <= s_logit;
						// insert into the sorted list, shifting lower entries down
						if (ins_found) begin
							for (int j = 1; j < NUM_CHOSEN; j++) begin
								if (j > int'(ins_pos)) begin
									best_idx_q[j]   <= best_idx_q[j-1];
									best_logit_q[j] <= best_logit_q[j-1];
								end
							end
							best_idx_q[ins_pos]   <= cnt_q;
							best_logit_q[ins_pos] <= s_logit;
						end
						if (cnt_q == IDX_W'(NUM_EXPERTS - 1)) begin
							cnt_q    <= '0;
							sum_q    <= '0;
							rd_idx_q <= '0;
							state_q  <= ST_SUM_RD;
						end else begin
							cnt_q <= cnt_q + IDX_W'(1);
						end
					end
				end
				ST_SUM_RD: begin
					state_q <= ST_SUM_EXP;
				end
				ST_SUM_EXP: begin
					state_q <= ST_SUM_WAIT;
				end
				ST_SUM_WAIT: begin
					if (exp_done) begin
						sum_q <= sum_q + smr_pkg::SUM_W'(exp_res);
						if (rd_idx_q == IDX_W'(NUM_EXPERTS - 1)) begin
							k_q     <= '0;
							state_q <= ST_SEL_EXP;
						end else begin
							rd_idx_q <= rd_idx_q + IDX_W'(1);
							state_q  <= ST_SUM_RD;
						end
					end
				end
				ST_SEL_EXP: begin
					state_q <= ST_SEL_WAIT;
				end
				ST_SEL_WAIT: begin
					if (exp_done)
						state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold the item until taken, then advance or close the set
					if (m_axis_tready) begin
						m_valid_q <= 1'b0;
						if (k_q == KW'(NRES - 1)) begin
							max_q   <= smr_pkg::LOGIT_MIN;
							sum_q   <= '0;
							k_q     <= '0;
							for (int j = 0; j < NUM_CHOSEN; j++) begin
								best_idx_q[j]   <= '0;
								best_logit_q[j] <= smr_pkg::LOGIT_MIN;
							end
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= ST_SEL_EXP;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// saturate the quotient; an empty sum gives zero weight
	always_ff @(posedge clk) begin
		if (div_done) begin
			if (sum_q == '0)
				weight_q <= '0;
			else if (div_quo > smr_pkg::NUM_W'(smr_pkg::WEIGHT_MAX))
				weight_q <= smr_pkg::WEIGHT_MAX;
			else
				weight_q <= div_quo[smr_pkg::WEIGHT_W-1:0];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'd0, weight_q,
	                        smr_pkg::OUT_IDX_W'(best_idx_q[k_q])};
	assign m_axis_tlast  = (k_q == KW'(NRES - 1));

endmodule

/* src/smr_exp.sv */
// Three-stage fixed-point exp(-e) unit: log2(e) scale, table interpolation, shift.
`timescale 1ns / 1ps

module smr_exp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [smr_pkg::LOGIT_W-1:0]   diff,
	output logic                          done,
	output logic [smr_pkg::EXP_W-1:0]     result
);

	logic                          v_s1, v_s2, v_s3;
	logic [smr_pkg::Y_W-1:0]       y_s1;
	logic [smr_pkg::EXP_W-1:0]     t_hi_s2;
	logic [2*smr_pkg::DIFF_W-1:0]  prod_s2;
	logic [8:0]                    n_s2;
	logic [smr_pkg::EXP_W-1:0]     res_s3;

	logic [3:0]                    tab_i;
	logic [smr_pkg::FRAC_W-1:0]    frac_r;
	logic [smr_pkg::EXP_W-1:0]     t_hi, t_lo;
	logic [smr_pkg::DIFF_W-1:0]    t_gap;
	logic [2*smr_pkg::DIFF_W:0]    rnd_sum;
	logic [smr_pkg::EXP_W-1:0]     v_interp;

	assign tab_i  = y_s1[15:12];
	assign frac_r = y_s1[11:0];
	assign t_hi   = smr_pkg::pow2_tab({1'b0, tab_i});
	assign t_lo   = smr_pkg::pow2_tab({1'b0, tab_i} + 5'd1);
	assign t_gap  = smr_pkg::DIFF_W'(t_hi - t_lo);

	assign rnd_sum  = {1'b0, prod_s2} + (2*smr_pkg::DIFF_W+1)'(2048);
	assign v_interp = t_hi_s2 - smr_pkg::EXP_W'(rnd_sum[2*smr_pkg::DIFF_W:12]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		// scale the distance from the maximum into base-2 exponent, Q.16
		y_s1    <= smr_pkg::Y_W'(diff) * smr_pkg::Y_W'(smr_pkg::LOG2E_Q8);
		// integer part, table entry and interpolation product
		n_s2    <= y_s1[24:16];
		t_hi_s2 <= t_hi;
		prod_s2 <= t_gap * frac_r;
		// drop to zero once the shift empties the value
		if (n_s2 > 9'd16)
			res_s3 <= '0;
		else
			res_s3 <= v_interp >> n_s2[4:0];
	end

	assign done   = v_s3;
	assign result = res_s3;

endmodule

/* src/smr_div.sv */
// Restoring divider, one quotient bit per cycle, for the softmax normalization.
`timescale 1ns / 1ps

module smr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [smr_pkg::NUM_W-1:0]   dividend,
	input  logic [smr_pkg::SUM_W-1:0]   divisor,
	output logic                        done,
	output logic [smr_pkg::NUM_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(smr_pkg::NUM_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [smr_pkg::SUM_W:0]     rem_q;
	logic [smr_pkg::NUM_W-1:0]   quo_q;
	logic [smr_pkg::SUM_W-1:0]   den_q;

	logic [smr_pkg::SUM_W:0]     rem_sh;
	logic [smr_pkg::SUM_W:0]     rem_sub;
	logic                        fits;

	assign rem_sh  = {rem_q[smr_pkg::SUM_W-1:0], quo_q[smr_pkg::NUM_W-1]};
	assign fits    = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(smr_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quo_q <= {quo_q[smr_pkg::NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
